>>> rtl/mvps_pkg.sv
// Shared types, constants and helper functions for the memory pattern search unit.
package mvps_pkg;

    localparam int LANES      = 8;
    localparam int BEAT_BYTES = 8;
    localparam int NLANE      = (LANES < BEAT_BYTES) ? LANES : BEAT_BYTES;

    localparam int DATA_W     = 8 * BEAT_BYTES;
    localparam int VB_W       = 4;
    localparam int ADDR_W     = 39;
    localparam int NEEDLE_W   = 32;
    localparam int COUNT_W    = 24;
    localparam int WIN_BYTES  = 3;
    localparam int WIN_W      = 8 * WIN_BYTES;
    localparam int TCNT_W     = 2;
    localparam int EXT_W      = WIN_W + 8 * NLANE;
    localparam int IDX_W      = (NLANE > 1) ? $clog2(NLANE) : 1;
    localparam int KEEP_W     = $clog2(NLANE + 1);

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FILL_W     = PTR_W + 1;

    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [COUNT_W-1:0] RESULT_LIMIT_RESET = 24'd1024;

    typedef enum logic [0:0] {
        REG_NEEDLE       = 1'b0,
        REG_RESULT_LIMIT = 1'b1
    } reg_idx_t;

    typedef logic [NLANE-1:0] hit_mask_t;

    // Beat after the lane compare stage
    typedef struct packed {
        hit_mask_t         hits;
        logic [ADDR_W-1:0] addr;
        logic              scan_start;
    } beat_t;

    // Queue entry: hits that survived the result limit
    typedef struct packed {
        hit_mask_t         hits;
        logic [ADDR_W-1:0] addr;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } push_t;

    function automatic logic [IDX_W-1:0] first_one(input hit_mask_t m);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = NLANE - 1; i >= 0; i--) begin
            if (m[i]) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

>>> rtl/mvps_lanes.sv
// Byte-offset compare lanes, trailing window and the first pipeline register.
module mvps_lanes (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [mvps_pkg::NEEDLE_W-1:0]       needle,
    input  logic                                in_fire,
    input  logic [mvps_pkg::DATA_W-1:0]         memory_bytes,
    input  logic [mvps_pkg::VB_W-1:0]           valid_bytes,
    input  logic [mvps_pkg::ADDR_W-1:0]         beat_address,
    input  logic                                region_first,
    input  logic                                region_scanned,
    input  logic                                scan_start,
    input  logic                                advance,
    output logic                                s1_valid,
    output mvps_pkg::beat_t                     s1_beat
);

    logic [mvps_pkg::WIN_W-1:0]  hist_reg, hist_next;
    logic [mvps_pkg::TCNT_W-1:0] tcnt_reg, tcnt_next;
    logic [mvps_pkg::TCNT_W-1:0] t_eff;
    logic [mvps_pkg::VB_W-1:0]   n_eff;
    logic [mvps_pkg::VB_W-1:0]   total;
    logic [mvps_pkg::EXT_W-1:0]  ext;
    logic [mvps_pkg::EXT_W-1:0]  ext_shift;
    mvps_pkg::hit_mask_t         hits;
    mvps_pkg::beat_t             s1_reg, s1_next;
    logic                        s1_valid_reg, s1_valid_next;

    always_comb
    begin
        t_eff = (region_first || !region_scanned) ? '0 : tcnt_reg;
        n_eff = (valid_bytes > mvps_pkg::VB_W'(mvps_pkg::NLANE))
              ? mvps_pkg::VB_W'(mvps_pkg::NLANE) : valid_bytes;
        // window bytes sit just below the beat bytes, newest at the top
        ext   = {memory_bytes[8*mvps_pkg::NLANE-1:0], hist_reg};
        for (int q = 0; q < mvps_pkg::NLANE; q++)
        begin
            hits[q] = region_scanned
                    && (ext[8*q +: mvps_pkg::NEEDLE_W] == needle)
                    && ((q + int'(t_eff)) >= mvps_pkg::WIN_BYTES)
                    && (mvps_pkg::VB_W'(q) < n_eff);
        end
        ext_shift = ext >> {n_eff, 3'b000};
        total     = mvps_pkg::VB_W'(t_eff) + n_eff;

        hist_next = hist_reg;
        tcnt_next = tcnt_reg;
        if (in_fire)
        begin
            if (!region_scanned)
            begin
                tcnt_next = '0;
            end
            else
            begin
                hist_next = ext_shift[mvps_pkg::WIN_W-1:0];
                tcnt_next = (total >= mvps_pkg::VB_W'(mvps_pkg::WIN_BYTES))
                          ? mvps_pkg::TCNT_W'(mvps_pkg::WIN_BYTES)
                          : total[mvps_pkg::TCNT_W-1:0];
            end
        end

        s1_next       = s1_reg;
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_next.hits       = hits;
            s1_next.addr       = beat_address;
            s1_next.scan_start = scan_start;
            s1_valid_next      = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tcnt_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            tcnt_reg     <= tcnt_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hist_reg <= hist_next;
        s1_reg   <= s1_next;
    end

    assign s1_valid = s1_valid_reg;
    assign s1_beat  = s1_reg;

endmodule

>>> rtl/mvps_merge.sv
// Merge stage: applies the result limit to the lane hits and keeps the match count.
module mvps_merge (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [mvps_pkg::COUNT_W-1:0]   result_limit,
    input  logic                           s1_valid,
    input  mvps_pkg::beat_t                s1_beat,
    input  logic                           fifo_full,
    output logic                           advance,
    output mvps_pkg::push_t                push
);

    logic [mvps_pkg::COUNT_W-1:0] match_count_reg, match_count_next;
    logic [mvps_pkg::COUNT_W-1:0] cnt;
    logic [mvps_pkg::COUNT_W-1:0] room;
    logic [mvps_pkg::KEEP_W-1:0]  room_cap;
    logic [mvps_pkg::KEEP_W-1:0]  running;
    mvps_pkg::hit_mask_t          keep;

    always_comb
    begin
        cnt      = s1_beat.scan_start ? '0 : match_count_reg;
        room     = (result_limit > cnt) ? (result_limit - cnt) : '0;
        room_cap = (room >= mvps_pkg::COUNT_W'(mvps_pkg::NLANE))
                 ? mvps_pkg::KEEP_W'(mvps_pkg::NLANE) : room[mvps_pkg::KEEP_W-1:0];
        // keep hits in address order until the remaining budget is used up
        running = '0;
        for (int q = 0; q < mvps_pkg::NLANE; q++)
        begin
            keep[q] = s1_beat.hits[q] && (running < room_cap);
            if (keep[q])
            begin
                running = running + 1'b1;
            end
        end

        advance          = !((|keep) && fifo_full);
        push.valid       = s1_valid && (|keep) && !fifo_full;
        push.entry.hits  = keep;
        push.entry.addr  = s1_beat.addr;

        match_count_next = match_count_reg;
        if (s1_valid && advance)
        begin
            match_count_next = cnt + mvps_pkg::COUNT_W'(running);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_count_reg <= '0;
        end
        else
        begin
            match_count_reg <= match_count_next;
        end
    end

endmodule

>>> rtl/mvps_emit.sv
// Result queue and emitter: one hit address per output item, lowest offset first.
module mvps_emit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mvps_pkg::push_t                push,
    output logic                           fifo_full,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [mvps_pkg::ADDR_W-1:0]    match_address,
    output logic                           last_in_beat
);

    mvps_pkg::entry_t            fifo_mem [mvps_pkg::FIFO_DEPTH];
    logic [mvps_pkg::PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [mvps_pkg::PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [mvps_pkg::FILL_W-1:0] fill_reg, fill_next;
    mvps_pkg::hit_mask_t         done_reg, done_next;
    mvps_pkg::entry_t            head;
    mvps_pkg::hit_mask_t         cur;
    mvps_pkg::hit_mask_t         sel;
    logic [mvps_pkg::IDX_W-1:0]  idx;
    logic                        last;
    logic                        fire;
    logic                        pop;

    always_comb
    begin
        head = fifo_mem[rd_ptr_reg];
        cur  = head.hits & ~done_reg;
        idx  = mvps_pkg::first_one(cur);
        sel  = mvps_pkg::hit_mask_t'(1) << idx;
        last = (cur & ~sel) == '0;

        out_valid     = fill_reg != '0;
        fifo_full     = fill_reg == mvps_pkg::FILL_W'(mvps_pkg::FIFO_DEPTH);
        // lane q compares window-relative byte q, which lies q-3 past the beat start
        match_address = head.addr + mvps_pkg::ADDR_W'(idx)
                      - mvps_pkg::ADDR_W'(mvps_pkg::WIN_BYTES);
        last_in_beat  = last;

        fire = out_valid && !out_stall;
        pop  = fire && last;

        done_next = done_reg;
        if (fire)
        begin
            done_next = last ? '0 : (done_reg | sel);
        end

        wr_ptr_next = push.valid ? (wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? (rd_ptr_reg + 1'b1) : rd_ptr_reg;
        case ({push.valid, pop})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            done_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            fifo_mem[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

>>> rtl/memory_value_pattern_search_unit.sv
// Top level of the memory pattern search unit: config registers and stage wiring.
//
// Input channel: one memory beat per item (memory_bytes, valid_bytes, beat_address,
// region_first, region_scanned, scan_start), taken when in_valid is high and
// in_stall is low. A beat can be taken every cycle.
// Output channel: one item per hit, the address of the hit's first byte, in
// address order; last_in_beat marks the final hit of a beat. Beats with no
// reported hits give no output item.
// Path: a taken beat is registered in the lane stage, then its hits are queued.
// Throughput: one beat per cycle in while in_stall is low, one hit per cycle out
// while out_stall is low; eight compare lanes check every byte offset of a beat in
// the same cycle; the one output port sets the rate when beats carry several hits.
// A four-entry hit queue sits between the merge stage and the output. When the
// receiver stalls the queue fills, and once it is full and a beat with hits is
// waiting, in_stall rises; beats are not lost.
// Config: needle at 0x0, result_limit at 0x4. The user writes them only while idle;
// the block does not enforce this. Reset: window, match count, queue and pipeline
// are emptied; needle is 0 and result_limit is 1024.
module memory_value_pattern_search_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mvps_pkg::PADDR_W-1:0]    paddr,
    input  logic [mvps_pkg::PDATA_W-1:0]    pwdata,
    output logic [mvps_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [mvps_pkg::DATA_W-1:0]     memory_bytes,
    input  logic [mvps_pkg::VB_W-1:0]       valid_bytes,
    input  logic [mvps_pkg::ADDR_W-1:0]     beat_address,
    input  logic                            region_first,
    input  logic                            region_scanned,
    input  logic                            scan_start,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [mvps_pkg::ADDR_W-1:0]     match_address,
    output logic                            last_in_beat
);

    logic [mvps_pkg::NEEDLE_W-1:0] needle_reg, needle_next;
    logic [mvps_pkg::COUNT_W-1:0]  limit_reg, limit_next;
    logic                          cfg_write;
    mvps_pkg::reg_idx_t            reg_idx;
    logic                          in_fire;
    logic                          s1_valid;
    mvps_pkg::beat_t               s1_beat;
    logic                          advance;
    mvps_pkg::push_t               push;
    logic                          fifo_full;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = mvps_pkg::reg_idx_t'(paddr[2]);

    always_comb
    begin
        needle_next = needle_reg;
        limit_next  = limit_reg;
        prdata      = '0;
        case (reg_idx)
            mvps_pkg::REG_NEEDLE:
            begin
                prdata = needle_reg;
                if (cfg_write)
                begin
                    needle_next = pwdata;
                end
            end
            mvps_pkg::REG_RESULT_LIMIT:
            begin
                prdata = mvps_pkg::PDATA_W'(limit_reg);
                if (cfg_write)
                begin
                    limit_next = pwdata[mvps_pkg::COUNT_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_reg <= '0;
            limit_reg  <= mvps_pkg::RESULT_LIMIT_RESET;
        end
        else
        begin
            needle_reg <= needle_next;
            limit_reg  <= limit_next;
        end
    end

    assign in_stall = s1_valid && !advance;
    assign in_fire  = in_valid && !in_stall;

    mvps_lanes u_lanes (
        .clk            (clk),
        .rst_n          (rst_n),
        .needle         (needle_reg),
        .in_fire        (in_fire),
        .memory_bytes   (memory_bytes),
        .valid_bytes    (valid_bytes),
        .beat_address   (beat_address),
        .region_first   (region_first),
        .region_scanned (region_scanned),
        .scan_start     (scan_start),
        .advance        (advance),
        .s1_valid       (s1_valid),
        .s1_beat        (s1_beat)
    );

    mvps_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .result_limit (limit_reg),
        .s1_valid     (s1_valid),
        .s1_beat      (s1_beat),
        .fifo_full    (fifo_full),
        .advance      (advance),
        .push         (push)
    );

    mvps_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .fifo_full     (fifo_full),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .match_address (match_address),
        .last_in_beat  (last_in_beat)
    );

`ifndef ASSERT_OFF
    // input back-pressure only ever comes from a held beat in the first stage
    a_stall_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid)
        else $error("in_stall without a beat in the lane stage");

    // and only when the hit queue is full
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> fifo_full)
        else $error("in_stall while the hit queue has room");

    // a beat's hits keep coming until the one marked last
    a_beat_not_cut: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_in_beat) |=> out_valid)
        else $error("hits of a beat dropped before its last one");
`endif

endmodule

>>> verif/memory_value_pattern_search_unit_tb.sv
// Self-checking testbench for the memory pattern search unit: directed table, then random beats.
module memory_value_pattern_search_unit_tb;

    localparam int ADDR_W   = mvps_pkg::ADDR_W;
    localparam int DATA_W   = mvps_pkg::DATA_W;
    localparam int VB_W     = mvps_pkg::VB_W;
    localparam int PADDR_W  = mvps_pkg::PADDR_W;
    localparam int PDATA_W  = mvps_pkg::PDATA_W;
    localparam int NEEDLE_W = mvps_pkg::NEEDLE_W;
    localparam int COUNT_W  = mvps_pkg::COUNT_W;
    localparam int WIN_W    = mvps_pkg::WIN_W;
    localparam int NLANE    = mvps_pkg::NLANE;

    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 10;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 30;
    localparam int MAX_PRINTS   = 50;

    typedef struct {
        logic [DATA_W-1:0] data;
        logic [VB_W-1:0]   vb;
        logic [ADDR_W-1:0] addr;
        logic              rf;
        logic              rs;
        logic              ss;
    } scan_beat_t;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic              last;
    } hit_t;

    typedef enum int {
        ROW_BEAT,
        ROW_NEEDLE,
        ROW_LIMIT
    } row_op_t;

    typedef struct {
        row_op_t           op;
        scan_beat_t        beat;
        logic [31:0]       value;
        int                n_typed;    // -1: take the predictor's hits
        logic [ADDR_W-1:0] first;
    } dir_row_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                in_valid;
    logic                in_stall;
    logic [DATA_W-1:0]   memory_bytes;
    logic [VB_W-1:0]     valid_bytes;
    logic [ADDR_W-1:0]   beat_address;
    logic                region_first;
    logic                region_scanned;
    logic                scan_start;
    logic                out_valid;
    logic                out_stall;
    logic [ADDR_W-1:0]   match_address;
    logic                last_in_beat;

    // predictor copy of registers and state
    logic [NEEDLE_W-1:0] needle_q;
    logic [COUNT_W-1:0]  limit_q;
    logic [WIN_W-1:0]    win_bytes;
    int                  win_count;
    logic [COUNT_W-1:0]  found_count;

    hit_t                beat_hits[$];
    hit_t                awaited[$];
    hit_t                head_hit;
    dir_row_t            rows[$];
    logic [7:0]          planted[$];

    logic [ADDR_W-1:0]   gen_addr;
    bit                  new_region;
    bit                  calm;
    bit                  hold_req;
    int                  hold_left;
    int                  idle_cycles;
    int                  fails;

    memory_value_pattern_search_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .memory_bytes   (memory_bytes),
        .valid_bytes    (valid_bytes),
        .beat_address   (beat_address),
        .region_first   (region_first),
        .region_scanned (region_scanned),
        .scan_start     (scan_start),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .match_address  (match_address),
        .last_in_beat   (last_in_beat)
    );

    always #1 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        fails++;
        if (fails <= MAX_PRINTS)
        begin
            $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
        end
    endtask

    // Searches one accepted beat; hits land in beat_hits
    function automatic void search_beat(input scan_beat_t b);
        logic [7:0]  seq [0:10];
        logic [31:0] w;
        int          n;
        int          t;
        int          total;
        int          keep;
        int          k;
        int          p;
        hit_t        h;
        beat_hits.delete();
        if (b.ss)
        begin
            found_count = '0;
        end
        if (b.rf)
        begin
            win_bytes = '0;
            win_count = 0;
        end
        if (!b.rs)
        begin
            win_bytes = '0;
            win_count = 0;
            return;
        end
        n = (b.vb > NLANE) ? NLANE : int'(b.vb);
        t = win_count;
        for (k = 0; k < t; k++)
        begin
            seq[k] = win_bytes[8*k +: 8];
        end
        for (k = 0; k < n; k++)
        begin
            seq[t+k] = b.data[8*k +: 8];
        end
        total = t + n;
        for (p = 0; p + 4 <= total; p++)
        begin
            w = {seq[p+3], seq[p+2], seq[p+1], seq[p]};
            if (w != needle_q)
            begin
                continue;
            end
            if (found_count >= limit_q || beat_hits.size() >= 8)
            begin
                break;
            end
            h.addr = b.addr - ADDR_W'(t) + ADDR_W'(p);
            h.last = 1'b0;
            beat_hits.insert(beat_hits.size(), h);
            found_count = found_count + 1'b1;
        end
        if (beat_hits.size() > 0)
        begin
            beat_hits[beat_hits.size()-1].last = 1'b1;
        end
        keep = (total < 3) ? total : 3;
        win_bytes = '0;
        for (k = 0; k < keep; k++)
        begin
            win_bytes[8*k +: 8] = seq[total-keep+k];
        end
        win_count = keep;
    endfunction

    task automatic send_beat(input scan_beat_t b, input int n_typed,
                             input logic [ADDR_W-1:0] first);
        int   i;
        hit_t h;
        @(negedge clk);
        while (!calm && $urandom_range(99) < 31)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        memory_bytes   <= b.data;
        valid_bytes    <= b.vb;
        beat_address   <= b.addr;
        region_first   <= b.rf;
        region_scanned <= b.rs;
        scan_start     <= b.ss;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        search_beat(b);
        if (n_typed < 0)
        begin
            for (i = 0; i < beat_hits.size(); i++)
            begin
                awaited.insert(awaited.size(), beat_hits[i]);
            end
        end
        else
        begin
            for (i = 0; i < n_typed; i++)
            begin
                h.addr = first + ADDR_W'(i);
                h.last = (i == n_typed - 1);
                awaited.insert(awaited.size(), h);
            end
        end
    endtask

    // Stop offering, drain every awaited hit, then let the pipeline empty
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input mvps_pkg::reg_idx_t idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        if (idx == mvps_pkg::REG_NEEDLE)
        begin
            needle_q = value;
        end
        else
        begin
            limit_q = value[COUNT_W-1:0];
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic dir_row_t beat_row(input logic [DATA_W-1:0] data,
                                          input logic [VB_W-1:0] vb,
                                          input logic [ADDR_W-1:0] addr,
                                          input logic rf, input logic rs, input logic ss,
                                          input int n_typed,
                                          input logic [ADDR_W-1:0] first);
        dir_row_t r;
        r.op        = ROW_BEAT;
        r.beat.data = data;
        r.beat.vb   = vb;
        r.beat.addr = addr;
        r.beat.rf   = rf;
        r.beat.rs   = rs;
        r.beat.ss   = ss;
        r.value     = '0;
        r.n_typed   = n_typed;
        r.first     = first;
        return r;
    endfunction

    function automatic dir_row_t cfg_row(input row_op_t op, input logic [31:0] value);
        dir_row_t r;
        r = beat_row('0, '0, '0, 1'b0, 1'b0, 1'b0, 0, '0);
        r.op    = op;
        r.value = value;
        return r;
    endfunction

    function automatic void add_row(input dir_row_t r);
        rows.insert(rows.size(), r);
    endfunction

    task automatic build_table();
        logic [ADDR_W-1:0] top;
        top = '1;
        // needle and limit at reset values: all-zero memory hits at every offset
        add_row(beat_row(64'h0, 4'd8, 39'h100, 1, 1, 1, 5, 39'h100));
        add_row(beat_row(64'h0, 4'd8, 39'h108, 0, 1, 0, 8, 39'h105));
        add_row(cfg_row(ROW_NEEDLE, 32'h4433_2211));
        add_row(beat_row(64'h0000_0000_4433_2211, 4'd8, 39'h2000, 1, 1, 1, 1, 39'h2000));
        add_row(beat_row(64'h4433_2211_0000_0000, 4'd8, 39'h2008, 0, 1, 0, 1, 39'h200C));
        // hit split across two beats
        add_row(beat_row(64'h3322_1100_0000_0000, 4'd8, 39'h2010, 0, 1, 0, 0, '0));
        add_row(beat_row(64'h44, 4'd1, 39'h2018, 0, 1, 0, 1, 39'h2015));
        // new region breaks the window
        add_row(beat_row(64'h3322_1100_0000_0000, 4'd8, 39'h3000, 1, 1, 0, 0, '0));
        add_row(beat_row(64'h44, 4'd8, 39'h3008, 1, 1, 0, 0, '0));
        // unsearched region: ignored and window cleared
        add_row(beat_row(64'h3322_1100_0000_0000, 4'd8, 39'h4000, 1, 1, 0, 0, '0));
        add_row(beat_row(64'h4433_2211_4433_2211, 4'd8, 39'h4008, 0, 0, 0, 0, '0));
        add_row(beat_row(64'h44, 4'd8, 39'h4010, 0, 1, 0, 0, '0));
        // empty beat keeps the window
        add_row(beat_row(64'h3322_1100_0000_0000, 4'd8, 39'h5000, 1, 1, 0, 0, '0));
        add_row(beat_row('1, 4'd0, 39'h5008, 0, 1, 0, 0, '0));
        add_row(beat_row(64'h44, 4'd1, 39'h5008, 0, 1, 0, -1, '0));
        // short beat, then oversized valid_bytes
        add_row(beat_row(64'h0000_0000_4433_2211, 4'd3, 39'h6000, 1, 1, 0, -1, '0));
        add_row(beat_row(64'h44, 4'd1, 39'h6003, 0, 1, 0, -1, '0));
        add_row(beat_row(64'h4433_2211_0000_0000, 4'd15, 39'h7000, 1, 1, 0, -1, '0));
        add_row(beat_row(64'h0044_3322_1100_0000, 4'd9, 39'h7008, 0, 1, 0, -1, '0));
        // address wraps at the top of the space
        add_row(beat_row(64'h3322_1100_0000_0000, 4'd8, top - 39'd7, 1, 1, 0, -1, '0));
        add_row(beat_row(64'h44, 4'd8, 39'h0, 0, 1, 0, -1, '0));
        add_row(beat_row(64'h4433_2211, 4'd4, top - 39'd3, 1, 1, 0, 1, top - 39'd3));
        add_row(cfg_row(ROW_NEEDLE, 32'hFFFF_FFFF));
        add_row(cfg_row(ROW_LIMIT, 32'd3));
        // limit reached, then cleared by scan_start
        add_row(beat_row('1, 4'd8, 39'h8000, 1, 1, 1, 3, 39'h8000));
        add_row(beat_row('1, 4'd8, 39'h8008, 0, 1, 0, 0, '0));
        add_row(beat_row('1, 4'd8, 39'h8010, 0, 1, 1, 3, 39'h800D));
        add_row(cfg_row(ROW_LIMIT, 32'd0));
        add_row(beat_row('1, 4'd8, 39'h9000, 1, 1, 1, 0, '0));
        add_row(cfg_row(ROW_LIMIT, 32'h00FF_FFFF));
        add_row(beat_row('1, 4'd8, 39'h9008, 0, 1, 1, 8, 39'h9005));
    endtask

    // Mostly contiguous regions with the needle planted; some pure noise
    task automatic make_beat(output scan_beat_t b);
        int         eff;
        int         k;
        int         j;
        logic [7:0] nb;
        if ($urandom_range(99) < 12)
        begin
            b.data = {$urandom, $urandom};
            b.vb   = VB_W'($urandom_range(15));
            b.addr = ADDR_W'({$urandom, $urandom});
            b.rf   = 1'($urandom);
            b.rs   = 1'($urandom);
            b.ss   = 1'($urandom);
            new_region = 1'b1;
            planted.delete();
        end
        else
        begin
            b.rf = new_region || ($urandom_range(9) == 0);
            new_region = 1'b0;
            if (b.rf)
            begin
                if ($urandom_range(7) == 0)
                begin
                    gen_addr = '1;
                    gen_addr = gen_addr - ADDR_W'($urandom_range(20));
                end
                else
                begin
                    gen_addr = ADDR_W'({$urandom, $urandom});
                end
                planted.delete();
            end
            b.rs = ($urandom_range(11) != 0);
            b.ss = ($urandom_range(9) == 0);
            b.vb = ($urandom_range(4) == 0) ? VB_W'($urandom_range(15)) : VB_W'(8);
            eff  = (b.vb > NLANE) ? NLANE : int'(b.vb);
            b.addr = gen_addr;
            for (k = 0; k < 8; k++)
            begin
                if (k < eff)
                begin
                    if (planted.size() == 0 && $urandom_range(6) == 0)
                    begin
                        for (j = 0; j < 4; j++)
                        begin
                            planted.insert(planted.size(), needle_q[8*j +: 8]);
                        end
                    end
                    if (planted.size() != 0)
                    begin
                        nb = planted.pop_front();
                    end
                    else if ($urandom_range(1) == 0)
                    begin
                        nb = needle_q[8*$urandom_range(3) +: 8];
                    end
                    else
                    begin
                        nb = 8'($urandom);
                    end
                end
                else
                begin
                    nb = 8'($urandom);
                end
                b.data[8*k +: 8] = nb;
            end
            gen_addr = gen_addr + ADDR_W'(eff);
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= !calm && ($urandom_range(99) < 31);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited.size() == 0)
            begin
                report_mismatch("unexpected match_address", match_address, '0);
            end
            else
            begin
                head_hit = awaited.pop_front();
                if (match_address !== head_hit.addr)
                begin
                    report_mismatch("match_address", match_address, head_hit.addr);
                end
                if (last_in_beat !== head_hit.last)
                begin
                    report_mismatch("last_in_beat", last_in_beat, head_hit.last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        scan_beat_t        b;
        logic [7:0]        x;
        logic [7:0]        y;
        logic [31:0]       nv;
        logic [31:0]       lv;
        int                ph;
        int                i;
        clk            = 1'b0;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_valid       = 1'b0;
        memory_bytes   = '0;
        valid_bytes    = '0;
        beat_address   = '0;
        region_first   = 1'b0;
        region_scanned = 1'b0;
        scan_start     = 1'b0;
        out_stall      = 1'b0;
        calm           = 1'b0;
        hold_req       = 1'b0;
        hold_left      = 0;
        idle_cycles    = 0;
        fails          = 0;
        needle_q       = '0;
        limit_q        = mvps_pkg::RESULT_LIMIT_RESET;
        win_bytes      = '0;
        win_count      = 0;
        found_count    = '0;
        gen_addr       = '0;
        new_region     = 1'b1;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(posedge clk);

        build_table();
        for (i = 0; i < rows.size(); i++)
        begin
            case (rows[i].op)
                ROW_NEEDLE:
                begin
                    settle();
                    write_reg(mvps_pkg::REG_NEEDLE, rows[i].value);
                end
                ROW_LIMIT:
                begin
                    settle();
                    write_reg(mvps_pkg::REG_RESULT_LIMIT, rows[i].value);
                end
                default:
                begin
                    send_beat(rows[i].beat, rows[i].n_typed, rows[i].first);
                end
            endcase
        end

        for (ph = 0; ph < PHASES; ph++)
        begin
            x = 8'($urandom);
            y = 8'($urandom);
            case (ph)
                1:       nv = {x, x, x, x};
                3:       nv = {y, x, y, x};
                4:       nv = 32'hFFFF_FFFF;
                5:       nv = 32'h0;
                default: nv = $urandom;
            endcase
            case (ph)
                1:       lv = $urandom_range(6, 1);
                2:       lv = 32'h00FF_FFFF;
                4:       lv = 32'd2;
                default: lv = $urandom_range(32'h00FF_FFFF, 16);
            endcase
            settle();
            write_reg(mvps_pkg::REG_NEEDLE, nv);
            write_reg(mvps_pkg::REG_RESULT_LIMIT, lv);
            @(posedge clk);
            calm = (ph == 2);
            if (ph == 3)
            begin
                hold_req = 1'b1;
            end
            new_region = 1'b1;
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                make_beat(b);
                send_beat(b, -1, '0);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
